>>> rtl/brf_pkg.sv
// shared types, mode codes and reset values for the banked register file
`timescale 1ns / 1ps

package brf_pkg;

	// operation codes
	localparam logic [1:0] OP_READ       = 2'd0;
	localparam logic [1:0] OP_WRITE      = 2'd1;
	localparam logic [1:0] OP_STATUS     = 2'd2;
	localparam logic [1:0] OP_SAVED      = 2'd3;

	// special register indexes
	localparam logic [4:0] IDX_CPSR      = 5'd16;
	localparam logic [4:0] IDX_SPSR      = 5'd17;

	// general register numbers
	localparam logic [3:0] REG_SP        = 4'd13;
	localparam logic [3:0] REG_LR        = 4'd14;
	localparam logic [3:0] REG_PC        = 4'd15;
	localparam logic [3:0] REG_HIGH_BASE = 4'd8;

	// processor modes
	localparam logic [4:0] MODE_USR      = 5'h10;
	localparam logic [4:0] MODE_FIQ      = 5'h11;
	localparam logic [4:0] MODE_IRQ      = 5'h12;
	localparam logic [4:0] MODE_SVC      = 5'h13;
	localparam logic [4:0] MODE_ABT      = 5'h17;
	localparam logic [4:0] MODE_UND      = 5'h1B;
	localparam logic [4:0] MODE_SYS      = 5'h1F;

	// stack pointer / link register bank slots
	localparam logic [2:0] SP_USR        = 3'd0;
	localparam logic [2:0] SP_FIQ        = 3'd1;
	localparam logic [2:0] SP_SVC        = 3'd2;
	localparam logic [2:0] SP_ABT        = 3'd3;
	localparam logic [2:0] SP_IRQ        = 3'd4;
	localparam logic [2:0] SP_UND        = 3'd5;

	// saved status slots
	localparam logic [2:0] PSR_FIQ       = 3'd0;
	localparam logic [2:0] PSR_SVC       = 3'd1;
	localparam logic [2:0] PSR_ABT       = 3'd2;
	localparam logic [2:0] PSR_IRQ       = 3'd3;
	localparam logic [2:0] PSR_UND       = 3'd4;

	localparam int NUM_LOW  = 8;
	localparam int NUM_HIGH = 5;
	localparam int NUM_SP   = 6;
	localparam int NUM_PSR  = 5;

	localparam logic [31:0] FLAG_MASK    = 32'hF000_0000;
	localparam logic [31:0] RST_PC       = 32'h0800_0000;
	localparam logic [31:0] RST_SP_USR   = 32'h0300_7F00;
	localparam logic [31:0] RST_SP_SVC   = 32'h0300_7FE0;
	localparam logic [31:0] RST_SP_IRQ   = 32'h0300_7FA0;
	localparam logic [31:0] RST_CPSR     = 32'h0000_005F;

	// decoded view of the current mode
	typedef struct packed {
		logic       usr;
		logic       fiq;
		logic       sys;
		logic       psr_ok;
		logic [2:0] sp_slot;
		logic [2:0] psr_slot;
	} mode_info_t;

endpackage

>>> rtl/brf_req_if.sv
// request channel carrying one register file access
`timescale 1ns / 1ps

interface brf_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [4:0]  register_index;
	logic [31:0] write_value;
	logic        flag_limit;

	modport source (
		output valid, operation, register_index, write_value, flag_limit,
		input  ready
	);
	modport sink (
		input  valid, operation, register_index, write_value, flag_limit,
		output ready
	);
endinterface

>>> rtl/brf_rsp_if.sv
// response channel carrying read data and error flag
`timescale 1ns / 1ps

interface brf_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        error;

	modport source (
		output valid, read_data, error,
		input  ready
	);
	modport sink (
		input  valid, read_data, error,
		output ready
	);
endinterface

>>> rtl/brf_mode_dec.sv
// decodes the status mode field into bank slot selects
`timescale 1ns / 1ps

module brf_mode_dec (
	input  logic [4:0]          mode,
	output brf_pkg::mode_info_t info
);

	always_comb begin
		info          = '0;
		info.sp_slot  = brf_pkg::SP_USR;
		info.psr_slot = brf_pkg::PSR_FIQ;
		case (mode)
			brf_pkg::MODE_USR: begin
				info.usr = 1'b1;
			end
			brf_pkg::MODE_FIQ: begin
				info.fiq      = 1'b1;
				info.psr_ok   = 1'b1;
				info.sp_slot  = brf_pkg::SP_FIQ;
				info.psr_slot = brf_pkg::PSR_FIQ;
			end
			brf_pkg::MODE_SVC: begin
				info.psr_ok   = 1'b1;
				info.sp_slot  = brf_pkg::SP_SVC;
				info.psr_slot = brf_pkg::PSR_SVC;
			end
			brf_pkg::MODE_ABT: begin
				info.psr_ok   = 1'b1;
				info.sp_slot  = brf_pkg::SP_ABT;
				info.psr_slot = brf_pkg::PSR_ABT;
			end
			brf_pkg::MODE_IRQ: begin
				info.psr_ok   = 1'b1;
				info.sp_slot  = brf_pkg::SP_IRQ;
				info.psr_slot = brf_pkg::PSR_IRQ;
			end
			brf_pkg::MODE_UND: begin
				info.psr_ok   = 1'b1;
				info.sp_slot  = brf_pkg::SP_UND;
				info.psr_slot = brf_pkg::PSR_UND;
			end
			brf_pkg::MODE_SYS: begin
				info.sys = 1'b1;
			end
			default: begin
				// unknown modes fall back to the user bank
				info.usr = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/banked_register_file_with_psr.sv
// Banked register file with current and saved status words.
// A request enters the input register; its response leaves from the result register.
// Throughput: one access per cycle when not stalled; the state is read, modified and written.
// A stalled response holds the input register, and the request side stalls behind it.
// Reset is asynchronous: registers take their architectural reset values, pipeline empties.
`timescale 1ns / 1ps

module banked_register_file_with_psr (
	input  logic      clk,
	input  logic      arst_n,
	brf_req_if.sink   req,
	brf_rsp_if.source rsp
);

	// input register
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [4:0]  idx_s1;
	logic [31:0] val_s1;
	logic        flags_s1;

	// result register
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        out_err_q;

	// architectural state
	logic [31:0] low_q  [brf_pkg::NUM_LOW];
	logic [31:0] high_q [brf_pkg::NUM_HIGH];
	logic [31:0] fast_q [brf_pkg::NUM_HIGH];
	logic [31:0] sp_q   [brf_pkg::NUM_SP];
	logic [31:0] lr_q   [brf_pkg::NUM_SP];
	logic [31:0] psr_q  [brf_pkg::NUM_PSR];
	logic [31:0] pc_q;
	logic [31:0] cpsr_q;

	brf_pkg::mode_info_t mi;

	logic        advance;
	logic [2:0]  hi_idx;
	logic [31:0] rd_data;
	logic        rd_err;
	logic        gp_we;
	logic        cpsr_we;
	logic [31:0] cpsr_d;
	logic        psr_we;
	logic [31:0] psr_d;
	logic [31:0] gp_rd;

	brf_mode_dec u_mode_dec (
		.mode (cpsr_q[4:0]),
		.info (mi)
	);

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign hi_idx    = 3'(idx_s1[3:0] - brf_pkg::REG_HIGH_BASE);

	// general register read through the current bank
	always_comb begin
		case (idx_s1[3:0]) inside
			[4'd0:4'd7]:       gp_rd = low_q[idx_s1[2:0]];
			[4'd8:4'd12]:      gp_rd = mi.fiq ? fast_q[hi_idx] : high_q[hi_idx];
			brf_pkg::REG_SP:   gp_rd = sp_q[mi.sp_slot];
			brf_pkg::REG_LR:   gp_rd = lr_q[mi.sp_slot];
			default:           gp_rd = pc_q;
		endcase
	end

	always_comb begin
		rd_data = '0;
		rd_err  = 1'b0;
		gp_we   = 1'b0;
		cpsr_we = 1'b0;
		cpsr_d  = val_s1;
		psr_we  = 1'b0;
		psr_d   = val_s1;
		case (op_s1)
			brf_pkg::OP_STATUS: begin
				cpsr_we = 1'b1;
				if (flags_s1 || mi.usr)
					cpsr_d = (cpsr_q & ~brf_pkg::FLAG_MASK) | (val_s1 & brf_pkg::FLAG_MASK);
			end
			brf_pkg::OP_SAVED: begin
				// system mode silently drops saved-status writes
				if (!mi.sys) begin
					if (!mi.psr_ok) begin
						rd_err = 1'b1;
					end else begin
						psr_we = 1'b1;
						if (flags_s1)
							psr_d = (psr_q[mi.psr_slot] & ~brf_pkg::FLAG_MASK) |
								(val_s1 & brf_pkg::FLAG_MASK);
					end
				end
			end
			brf_pkg::OP_READ: begin
				if (idx_s1 > brf_pkg::IDX_SPSR) begin
					rd_err = 1'b1;
				end else if (!idx_s1[4]) begin
					rd_data = gp_rd;
				end else if (idx_s1 == brf_pkg::IDX_CPSR || mi.sys) begin
					rd_data = cpsr_q;
				end else if (!mi.psr_ok) begin
					rd_err = 1'b1;
				end else begin
					rd_data = psr_q[mi.psr_slot];
				end
			end
			default: begin
				// plain write
				if (idx_s1 > brf_pkg::IDX_SPSR) begin
					rd_err = 1'b1;
				end else if (!idx_s1[4]) begin
					gp_we = 1'b1;
				end else if (idx_s1 == brf_pkg::IDX_CPSR) begin
					cpsr_we = 1'b1;
				end else if (!mi.sys) begin
					if (!mi.psr_ok)
						rd_err = 1'b1;
					else
						psr_we = 1'b1;
				end
			end
		endcase
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1    <= req.operation;
			idx_s1   <= req.register_index;
			val_s1   <= req.write_value;
			flags_s1 <= req.flag_limit;
		end
		if (advance) begin
			out_data_q <= rd_data;
			out_err_q  <= rd_err;
		end
	end

	// register state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < brf_pkg::NUM_LOW; i++)
				low_q[i] <= '0;
			for (int i = 0; i < brf_pkg::NUM_HIGH; i++) begin
				high_q[i] <= '0;
				fast_q[i] <= '0;
			end
			for (int i = 0; i < brf_pkg::NUM_SP; i++) begin
				sp_q[i] <= '0;
				lr_q[i] <= '0;
			end
			for (int i = 0; i < brf_pkg::NUM_PSR; i++)
				psr_q[i] <= '0;
			sp_q[brf_pkg::SP_USR] <= brf_pkg::RST_SP_USR;
			sp_q[brf_pkg::SP_SVC] <= brf_pkg::RST_SP_SVC;
			sp_q[brf_pkg::SP_IRQ] <= brf_pkg::RST_SP_IRQ;
			pc_q   <= brf_pkg::RST_PC;
			cpsr_q <= brf_pkg::RST_CPSR;
		end else if (advance) begin
			if (gp_we) begin
				case (idx_s1[3:0]) inside
					[4'd0:4'd7]: low_q[idx_s1[2:0]] <= val_s1;
					[4'd8:4'd12]: begin
						if (mi.fiq)
							fast_q[hi_idx] <= val_s1;
						else
							high_q[hi_idx] <= val_s1;
					end
					brf_pkg::REG_SP: sp_q[mi.sp_slot] <= val_s1;
					brf_pkg::REG_LR: lr_q[mi.sp_slot] <= val_s1;
					default:         pc_q <= val_s1;
				endcase
			end
			if (cpsr_we)
				cpsr_q <= cpsr_d;
			if (psr_we)
				psr_q[mi.psr_slot] <= psr_d;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.read_data = out_data_q;
	assign rsp.error     = out_err_q;

	// an error response never carries data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.error |-> rsp.read_data == '0)
		else $error("error response with non-zero data");

	// an empty input register always takes a transfer
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req.ready)
		else $error("input register empty but not ready");

	// every access that leaves the input register produces a response
	a_adv_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp.valid)
		else $error("access advanced without a response");

	// status word only changes through a status write
	a_cpsr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && cpsr_we) |=> $stable(cpsr_q))
		else $error("status word changed without a write");

	// user mode OP_STATUS writes touch the flags only
	a_usr_flags: assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 == brf_pkg::OP_STATUS && mi.usr
		|=> cpsr_q[27:0] == $past(cpsr_q[27:0]))
		else $error("user mode status write changed control bits");

endmodule
